### src/sida_pkg.sv
`timescale 1ns / 1ps

package sida_pkg;

    localparam int WORD_BITS  = 32;
    localparam int NUM_STAGES = 4;
    localparam int STEP_BITS  = (WORD_BITS + NUM_STAGES - 1) / NUM_STAGES;
    localparam int PAD_BITS   = STEP_BITS * NUM_STAGES;
    localparam int DIGITS     = (WORD_BITS * 301) / 1000 + 1;
    localparam int BCD_BITS   = DIGITS * 4;
    localparam int IDX_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CHAR_BITS  = 8;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic                neg;
        logic [PAD_BITS-1:0] bin;
        logic [BCD_BITS-1:0] bcd;
    } t_conv;

endpackage

### src/sida_dabble_stage.sv
`timescale 1ns / 1ps

module sida_dabble_stage
    import sida_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_conv i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_conv o_item
);

    logic  r_vld;
    t_conv r_item;
    t_conv n_item;

    always_comb begin
        logic [BCD_BITS-1:0] bcd;
        logic [PAD_BITS-1:0] bin;
        bcd = i_item.bcd;
        bin = i_item.bin;
        for (int s = 0; s < STEP_BITS; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (bcd[d*4 +: 4] >= 4'd5) begin
                    bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
                end
            end
            bcd = {bcd[BCD_BITS-2:0], bin[PAD_BITS-1]};
            bin = {bin[PAD_BITS-2:0], 1'b0};
        end
        n_item.neg = i_item.neg;
        n_item.bin = bin;
        n_item.bcd = bcd;
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

### src/sida_serializer.sv
`timescale 1ns / 1ps

module sida_serializer
    import sida_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_conv                i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CHAR_BITS-1:0] o_text_char,
    output logic                 o_last_char
);

    logic                 r_busy;
    logic                 r_neg;
    logic [IDX_W-1:0]     r_idx;
    logic [BCD_BITS-1:0]  r_bcd;
    logic                 r_ovld;
    logic [CHAR_BITS-1:0] r_char;
    logic                 r_last;

    logic                 w_emit;
    logic                 w_cur_last;
    logic                 w_accept;
    logic [IDX_W-1:0]     n_lead;
    logic [3:0]           w_digit;
    logic [CHAR_BITS-1:0] w_char;

    always_comb begin
        n_lead = '0;
        for (int k = 0; k < DIGITS; k++) begin
            if (i_item.bcd[k*4 +: 4] != 4'd0) begin
                n_lead = IDX_W'(k);
            end
        end
    end

    assign w_digit    = r_bcd[r_idx*4 +: 4];
    assign w_char     = r_neg ? CHAR_MINUS : (CHAR_ZERO + {{(CHAR_BITS-4){1'b0}}, w_digit});
    assign w_cur_last = !r_neg && (r_idx == '0);
    assign w_emit     = r_busy && (!r_ovld || i_ready);
    assign w_accept   = !r_busy || (w_emit && w_cur_last);
    assign o_ready    = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= i_valid;
            end
            if (!r_ovld || i_ready) begin
                r_ovld <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_valid) begin
            r_neg <= i_item.neg;
            r_idx <= n_lead;
            r_bcd <= i_item.bcd;
        end else if (w_emit) begin
            if (r_neg) begin
                r_neg <= 1'b0;
            end else if (r_idx != '0) begin
                r_idx <= r_idx - 1'b1;
            end
        end
        if (w_emit) begin
            r_char <= w_char;
            r_last <= w_cur_last;
        end
    end

    assign o_valid     = r_ovld;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

endmodule

### src/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

// Converts a signed two's complement integer into its decimal ASCII text, one
// character per output item, most significant first, with a leading '-' for
// negative values and last_char set on the final character; the most negative
// value converts exactly and zero gives a single '0'. An item passes an input
// register, four double-dabble stages and a character serializer with a registered
// output. The serializer sends one character per cycle while the output is ready,
// and an item holds it for as many characters as it has (digits plus sign, 1 to
// 11 for a 32-bit word), which sets the sustained rate; the pipeline ahead of it
// keeps up to five items queued.

module signed_int_to_decimal_ascii
    import sida_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [WORD_BITS-1:0] i_value,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CHAR_BITS-1:0] o_text_char,
    output logic                 o_last_char
);

    logic                 r_vld0;
    t_conv                r_item0;
    t_conv                n_item0;
    logic [WORD_BITS-1:0] w_mag;

    logic  w_vld [NUM_STAGES+1];
    logic  w_rdy [NUM_STAGES+1];
    t_conv w_item[NUM_STAGES+1];

    assign w_mag       = i_value[WORD_BITS-1] ? (~i_value + 1'b1) : i_value;
    assign n_item0.neg = i_value[WORD_BITS-1];
    assign n_item0.bin = PAD_BITS'(w_mag) << (PAD_BITS - WORD_BITS);
    assign n_item0.bcd = '0;

    assign o_ready = !r_vld0 || w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (o_ready) begin
            r_vld0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item0 <= n_item0;
        end
    end

    assign w_vld[0]  = r_vld0;
    assign w_item[0] = r_item0;

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        sida_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .o_ready (w_rdy[g]),
            .i_item  (w_item[g]),
            .o_valid (w_vld[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    sida_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_vld[NUM_STAGES]),
        .o_ready     (w_rdy[NUM_STAGES]),
        .i_item      (w_item[NUM_STAGES]),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule

### tb/sv/signed_int_to_decimal_ascii_test.sv
`timescale 1ns / 1ps

class DecimalTextScoreboard;
    localparam int RADIX = 10;

    typedef struct packed {
        logic [sida_pkg::CHAR_BITS-1:0] text_char;
        logic                           last_char;
    } t_text_item;

    t_text_item text_q[$];
    int         mismatch_count;

    function void note_value(logic [sida_pkg::WORD_BITS-1:0] word);
        logic [sida_pkg::WORD_BITS-1:0] mag;
        logic [sida_pkg::CHAR_BITS-1:0] digit_q[$];
        t_text_item                     item;
        mag = word[sida_pkg::WORD_BITS-1] ? (~word + 1'b1) : word;
        do begin
            digit_q.push_front(sida_pkg::CHAR_ZERO + 8'(mag % RADIX));
            mag = mag / RADIX;
        end while (mag != 0);
        if (word[sida_pkg::WORD_BITS-1]) begin
            item.text_char = sida_pkg::CHAR_MINUS;
            item.last_char = 1'b0;
            text_q.push_back(item);
        end
        foreach (digit_q[i]) begin
            item.text_char = digit_q[i];
            item.last_char = (i == digit_q.size() - 1);
            text_q.push_back(item);
        end
    endfunction

    function void check_char(logic [sida_pkg::CHAR_BITS-1:0] text_char, logic last_char);
        t_text_item want;
        if (text_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected char 0x%02h last %0b", text_char, last_char);
        end else begin
            want = text_q.pop_front();
            if (want.text_char !== text_char || want.last_char !== last_char) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("char mismatch: expected 0x%02h last %0b, got 0x%02h last %0b",
                             want.text_char, want.last_char, text_char, last_char);
            end
        end
    endfunction

    function int pending();
        return text_q.size();
    endfunction
endclass

module signed_int_to_decimal_ascii_test;
    import sida_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 20;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic [WORD_BITS-1:0] i_value     = '0;
    logic                 i_ready     = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [CHAR_BITS-1:0] o_text_char;
    logic                 o_last_char;

    DecimalTextScoreboard text_sb = new();
    int                   idle_cycles = 0;
    bit                   idling_on = 1'b1;
    bit                   hold_off_req = 1'b0;

    signed_int_to_decimal_ascii uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                text_sb.note_value(i_value);
            if (o_valid && i_ready)
                text_sb.check_char(o_text_char, o_last_char);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (idling_on && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("signed_int_to_decimal_ascii test failed");
        $finish;
    end

    task automatic send_value(input logic [WORD_BITS-1:0] value);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    function automatic logic [WORD_BITS-1:0] pick_value();
        int                   mode;
        int                   ndig;
        longint               lo;
        longint               hi;
        longint               pow;
        logic [WORD_BITS-1:0] value;
        mode = $urandom_range(0, 9);
        pow = 1;
        if (mode <= 3) begin
            value = $urandom();
        end else if (mode <= 7) begin
            ndig = $urandom_range(1, 10);
            repeat (ndig - 1) pow = pow * 10;
            lo = (ndig == 1) ? 0 : pow;
            hi = pow * 10 - 1;
            if (hi > 64'sd2147483647)
                hi = 64'sd2147483647;
            value = WORD_BITS'(lo + (longint'($urandom()) % (hi - lo + 1)));
            if ($urandom_range(0, 1))
                value = -value;
        end else if (mode == 8) begin
            repeat ($urandom_range(0, 9)) pow = pow * 10;
            value = WORD_BITS'(pow + $urandom_range(0, 2) - 1);
            if ($urandom_range(0, 1))
                value = -value;
        end else if ($urandom_range(0, 1)) begin
            value = 32'h8000_0000 + $urandom_range(0, 3);
        end else begin
            value = 32'h7FFF_FFFF - $urandom_range(0, 3);
        end
        return value;
    endfunction

    initial begin
        logic [WORD_BITS-1:0] directed_q[$];
        directed_q = '{32'd0, 32'd1, -32'd1, 32'd9, -32'd9, 32'd10, -32'd10, 32'd99,
                       32'd100, -32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                       32'h7FFF_FFFE, 32'd999999999, 32'd1000000000, -32'd1000000000,
                       -32'd999999999, 32'h5555_5555, 32'hAAAA_AAAA, 32'd12345,
                       -32'd67890, 32'd1999999999};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_q[i])
            send_value(directed_q[i]);
        repeat (180) send_value(pick_value());
        hold_off_req = 1'b1;
        repeat (25) send_value(pick_value());
        i_valid <= 1'b0;
        while (text_sb.pending() != 0) @(posedge i_clk);
        repeat (130) send_value(pick_value());
        idling_on = 1'b0;
        repeat (50) send_value(pick_value());
        i_valid <= 1'b0;
        while (text_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (text_sb.mismatch_count == 0)
            $display("signed_int_to_decimal_ascii test passed");
        else
            $display("signed_int_to_decimal_ascii test failed");
        $finish;
    end
endmodule
